### rtl/iscdf_pkg.sv
// shared types and constants for the importance sampling cdf builder
package iscdf_pkg;

    localparam logic [2:0] CMD_PUSH     = 3'd0;
    localparam logic [2:0] CMD_ROW_CDF  = 3'd1;
    localparam logic [2:0] CMD_MARG_CDF = 3'd2;
    localparam logic [2:0] CMD_INTEGRAL = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic [0:0] CFG_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_HEIGHT = 1'b1;

    localparam logic [20:0] TWO_PI_SQ_Q16 = 21'd1293629;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [15:0] intensity;
        logic [16:0]        row_weight;
        logic [6:0]         row_index;
        logic [8:0]         entry_index;
    } in_word_t;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } out_word_t;

    // jobs handed from the front to the back part
    typedef enum logic [2:0] {
        JOB_PUSH = 3'b001,
        JOB_READ = 3'b010,
        JOB_NONE = 3'b100
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [2:0]  command;
        logic [31:0] product;
        logic [6:0]  row_index;
        logic [8:0]  entry_index;
    } job_t;

endpackage

### rtl/iscdf_ram.sv
// generic ram with one write port and one read port, registered read
module iscdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### rtl/iscdf_front.sv
// front part: accepts words, forms the weighted product and queues jobs
module iscdf_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  iscdf_pkg::in_word_t s_data,
    output logic               job_valid,
    input  logic               job_ready,
    output iscdf_pkg::job_t    job
);
    import iscdf_pkg::*;

    localparam int QDEPTH = 4;

    job_t       q_reg [QDEPTH];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    job_t       nj;
    logic [15:0] inten;
    logic [16:0] wt;
    logic        push, pop;

    always_comb begin
        inten = s_data.intensity[15] ? 16'd0 : s_data.intensity;
        wt    = (s_data.row_weight > 17'd65536) ? 17'd65536 : s_data.row_weight;
        nj.command     = s_data.command;
        nj.product     = 32'(inten * wt);
        nj.row_index   = s_data.row_index;
        nj.entry_index = s_data.entry_index;
        unique case (s_data.command)
            CMD_PUSH: nj.kind = JOB_PUSH;
            CMD_ROW_CDF, CMD_MARG_CDF, CMD_INTEGRAL, CMD_CLEAR: nj.kind = JOB_READ;
            default: nj.kind = JOB_NONE;
        endcase
    end

    assign s_ready   = (cnt_reg != 3'(QDEPTH));
    assign push      = s_valid && s_ready && (nj.kind != JOB_NONE);
    assign job_valid = (cnt_reg != 3'd0);
    assign pop       = job_valid && job_ready;
    assign job       = q_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= nj;
        end
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop)  rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end
endmodule

### rtl/iscdf_back.sv
// back part: accumulates sums into memories and answers reads with a serial divider
module iscdf_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_sel,
    input  logic [8:0]           cfg_data,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  iscdf_pkg::job_t      job,
    output logic                 m_valid,
    input  logic                 m_ready,
    output iscdf_pkg::out_word_t m_data
);
    import iscdf_pkg::*;

    localparam int PIX  = MAX_WIDTH * MAX_HEIGHT;
    localparam int PAW  = $clog2(PIX);
    localparam int RAW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW   = $clog2(PIX + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ADDR  = 7'b0000010,
        S_WAIT  = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [8:0]  width_reg;
    logic [7:0]  height_reg;
    logic [CW-1:0] pcount_reg, total_reg;
    logic [8:0]  col_reg;
    logic [RAW-1:0] row_reg;
    logic [47:0] run_reg;
    logic [55:0] grand_reg;
    job_t        jb_reg;
    logic [1:0]  status_reg;
    logic [31:0] value_reg;
    logic        out_valid_reg;
    // divider
    logic [72:0] rem_reg;
    logic [72:0] den_reg;
    logic [55:0] quo_reg;
    logic [5:0]  step_reg;
    logic        sat_reg;
    logic [52:0] mul_reg;

    // memories
    logic            pp_we, rt_we;
    logic [PAW-1:0]  pp_waddr, pp_raddr;
    logic [47:0]     pp_rdata, rt_rdata, sum48;
    logic [55:0]     rp_rdata, grand_new;
    logic [RAW-1:0]  rt_raddr, rp_raddr;

    assign sum48     = run_reg + 48'(job.product);
    assign grand_new = grand_reg + 56'(sum48);
    assign pp_waddr  = PAW'(pcount_reg);

    iscdf_ram #(.WIDTH(48), .DEPTH(PIX)) u_pp (
        .aclk(aclk), .we(pp_we), .waddr(pp_waddr), .wdata(sum48),
        .raddr(pp_raddr), .rdata(pp_rdata));
    iscdf_ram #(.WIDTH(48), .DEPTH(MAX_HEIGHT)) u_rt (
        .aclk(aclk), .we(rt_we), .waddr(row_reg), .wdata(sum48),
        .raddr(rt_raddr), .rdata(rt_rdata));
    iscdf_ram #(.WIDTH(56), .DEPTH(MAX_HEIGHT)) u_rp (
        .aclk(aclk), .we(rt_we), .waddr(row_reg), .wdata(grand_new),
        .raddr(rp_raddr), .rdata(rp_rdata));

    logic is_push, full, last_col;
    assign is_push  = (state_reg == S_IDLE) && job_valid && (job.kind == JOB_PUSH);
    assign full     = (pcount_reg >= total_reg);
    assign last_col = (col_reg == width_reg - 9'd1);
    assign pp_we    = is_push && !full;
    assign rt_we    = pp_we && last_col;
    assign job_ready = (state_reg == S_IDLE) && (is_push || !out_valid_reg);

    // read address: row * width + col - 1, registered into the address stage
    logic [PAW-1:0] addr_reg;
    assign pp_raddr = addr_reg;
    assign rt_raddr = RAW'(jb_reg.row_index);
    assign rp_raddr = RAW'(jb_reg.entry_index - 9'd1);

    logic [8:0] wsat;
    logic [7:0] hsat;
    always_comb begin
        wsat = (cfg_data == 9'd0) ? 9'd1 :
               ({23'd0, cfg_data} > 32'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : cfg_data;
        hsat = (cfg_data[7:0] == 8'd0) ? 8'd1 :
               ({24'd0, cfg_data[7:0]} > 32'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : cfg_data[7:0];
    end

    logic range_bad;
    always_comb begin
        unique case (jb_reg.command)
            CMD_ROW_CDF:  range_bad = ({1'b0, jb_reg.row_index} >= height_reg) ||
                                      (jb_reg.entry_index > width_reg);
            CMD_MARG_CDF: range_bad = (jb_reg.entry_index > {1'b0, height_reg});
            default:      range_bad = 1'b0;
        endcase
    end

    logic [72:0] rem_sh;
    always_comb begin
        rem_sh = {rem_reg[71:0], 1'b0};
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (job_valid && job_ready && job.kind == JOB_READ &&
                        job.command != CMD_CLEAR) state_next = S_ADDR;
            S_ADDR: state_next = S_WAIT;
            S_WAIT: state_next = S_LOAD;
            S_LOAD: state_next = (status_reg != ST_OK || jb_reg.entry_index == 9'd0 &&
                                  jb_reg.command != CMD_INTEGRAL) ? S_OUT :
                                 (jb_reg.command == CMD_INTEGRAL) ? S_DIV : S_DIV;
            S_DIV:  if (step_reg == 6'd1) state_next =
                        (jb_reg.command == CMD_INTEGRAL) ? S_MUL : S_OUT;
            S_MUL:  state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && job_valid && job_ready) begin
            jb_reg <= job;
        end
        if (state_reg == S_ADDR) begin
            addr_reg   <= PAW'(32'(jb_reg.row_index) * 32'(width_reg) +
                               32'(jb_reg.entry_index) - 32'd1);
            status_reg <= !full ? ST_NOT_READY : range_bad ? ST_RANGE : ST_OK;
        end
        if (state_reg == S_LOAD) begin
            sat_reg  <= 1'b0;
            quo_reg  <= '0;
            unique case (jb_reg.command)
                CMD_ROW_CDF: begin
                    if (rt_rdata == 48'd0) begin
                        rem_reg <= 73'(jb_reg.entry_index);
                        den_reg <= 73'(width_reg);
                        sat_reg <= (jb_reg.entry_index >= width_reg);
                    end else begin
                        rem_reg <= 73'(pp_rdata);
                        den_reg <= 73'(rt_rdata);
                        sat_reg <= (pp_rdata >= rt_rdata);
                    end
                    step_reg <= 6'd16;
                end
                CMD_MARG_CDF: begin
                    if (grand_reg == 56'd0) begin
                        rem_reg <= 73'(jb_reg.entry_index);
                        den_reg <= 73'(height_reg);
                        sat_reg <= (jb_reg.entry_index >= {1'b0, height_reg});
                    end else begin
                        rem_reg <= 73'(rp_rdata);
                        den_reg <= 73'(grand_reg);
                        sat_reg <= (rp_rdata >= grand_reg);
                    end
                    step_reg <= 6'd16;
                end
                default: begin
                    // long division of grand total by pixel count, one bit a cycle
                    rem_reg  <= '0;
                    den_reg  <= 73'(total_reg);
                    quo_reg  <= grand_reg;
                    step_reg <= 6'd56;
                end
            endcase
        end
        if (state_reg == S_DIV) begin
            if (jb_reg.command == CMD_INTEGRAL) begin
                if ({rem_reg[71:0], quo_reg[55]} >= den_reg) begin
                    rem_reg <= {rem_reg[71:0], quo_reg[55]} - den_reg;
                    quo_reg <= {quo_reg[54:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[71:0], quo_reg[55]};
                    quo_reg <= {quo_reg[54:0], 1'b0};
                end
            end else if (rem_sh >= den_reg) begin
                rem_reg <= rem_sh - den_reg;
                quo_reg <= {quo_reg[54:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[54:0], 1'b0};
            end
            step_reg <= step_reg - 6'd1;
        end
        if (state_reg == S_MUL) begin
            // mean is below 2^31, so a 32 by 21 bit product covers it
            mul_reg <= 53'(quo_reg[31:0]) * 53'(TWO_PI_SQ_Q16);
        end
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            width_reg     <= 9'(MAX_WIDTH);
            height_reg    <= 8'(MAX_HEIGHT);
            total_reg     <= CW'(PIX);
            pcount_reg    <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            run_reg       <= '0;
            grand_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            if (state_reg == S_OUT) begin
                out_valid_reg <= 1'b1;
                if (status_reg != ST_OK) begin
                    value_reg <= '0;
                end else if (jb_reg.command == CMD_INTEGRAL) begin
                    value_reg <= {3'd0, mul_reg[52:24]};
                end else if (jb_reg.entry_index == 9'd0) begin
                    value_reg <= '0;
                end else if (sat_reg) begin
                    value_reg <= 32'd65536;
                end else begin
                    value_reg <= {16'd0, quo_reg[15:0]};
                end
            end
            if (pp_we) begin
                pcount_reg <= pcount_reg + CW'(1);
                if (last_col) begin
                    run_reg   <= '0;
                    grand_reg <= grand_new;
                    col_reg   <= '0;
                    row_reg   <= row_reg + RAW'(1);
                end else begin
                    run_reg <= sum48;
                    col_reg <= col_reg + 9'd1;
                end
            end
            if (state_reg == S_IDLE && job_valid && job_ready &&
                job.kind == JOB_READ && job.command == CMD_CLEAR) begin
                pcount_reg <= '0; col_reg <= '0; row_reg <= '0;
                run_reg <= '0; grand_reg <= '0;
            end
            if (cfg_we) begin
                if (cfg_sel == CFG_WIDTH) begin
                    width_reg <= wsat;
                    total_reg <= CW'(32'(wsat) * 32'(height_reg));
                end else begin
                    height_reg <= hsat;
                    total_reg  <= CW'(32'(width_reg) * 32'(hsat));
                end
                pcount_reg <= '0; col_reg <= '0; row_reg <= '0;
                run_reg <= '0; grand_reg <= '0;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_data.value  = value_reg;
    assign m_data.status = status_reg;
endmodule

### rtl/importance_sampling_cdf_builder_top.sv
// channel  | direction | handshake
// s_       | in        | s_valid / s_ready, word in_word_t
// m_       | out       | m_valid / m_ready, word out_word_t
// cfg_     | in        | cfg_we, no wait
// pushes: one per cycle sustained through a four word queue while no read is in progress
// cdf reads: address, wait, load, 16 step serial divide, output (no divide for entry 0 or a bad status)
// integral reads: address, wait, load, 56 step mean divide, multiply, output (a bad status skips to output)
// reset: synchronous active low aresetn, no clearing pass
module importance_sampling_cdf_builder_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  iscdf_pkg::in_word_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output iscdf_pkg::out_word_t m_data,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [8:0]           cfg_data
);
    import iscdf_pkg::*;

    logic job_valid, job_ready;
    job_t job;

    iscdf_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .job_valid(job_valid), .job_ready(job_ready), .job(job));

    iscdf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_sel(cfg_index),
        .cfg_data(cfg_data), .job_valid(job_valid), .job_ready(job_ready),
        .job(job), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));
endmodule

### rtl/iscdf_checker.sv
// port checker for the cdf builder
module iscdf_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input iscdf_pkg::out_word_t m_data
);
    import iscdf_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3) else $error("bad status");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.value == 32'd0) else $error("value");
endmodule

bind importance_sampling_cdf_builder_top iscdf_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));

### bench/importance_sampling_cdf_builder_top_tb.sv
// self-checking testbench for the importance sampling cdf builder top level
module importance_sampling_cdf_builder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import iscdf_pkg::*;

    localparam int MAX_W = 256;
    localparam int MAX_H = 128;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [63:0] ONE_Q16 = 64'd65536;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;
    logic      cfg_we = 1'b0;
    logic [0:0] cfg_index = CFG_WIDTH;
    logic [8:0] cfg_data = '0;

    importance_sampling_cdf_builder_top #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    // distribution state mirrored by the bench
    logic [63:0] pixel_prefix [0:MAX_W*MAX_H-1];
    logic [63:0] row_total [0:MAX_H-1];
    logic [63:0] row_prefix [0:MAX_H-1];
    logic [63:0] row_sum;
    logic [63:0] grand_sum;
    int unsigned pixels_loaded;
    int unsigned img_w;
    int unsigned img_h;

    out_word_t cdf_results_q[$];
    out_word_t want;
    int unsigned words_sent;
    int unsigned results_seen;
    int unsigned loads_done;
    int unsigned errors;
    int unsigned cycles;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    function automatic logic [31:0] q16_ratio(input logic [63:0] num, input logic [63:0] den);
        logic [127:0] wide;
        if (den == 0 || num >= den) return 32'd65536;
        wide = {64'd0, num} << 16;
        return 32'(wide / {64'd0, den});
    endfunction

    task automatic clear_load();
        pixels_loaded = 0;
        row_sum = '0;
        grand_sum = '0;
    endtask

    task automatic predict_word(input in_word_t w);
        logic [63:0] inten;
        logic [63:0] wt;
        logic [63:0] mean;
        logic [63:0] scaled;
        int unsigned total;
        int unsigned row;
        int unsigned col;
        out_word_t r;
        total = img_w * img_h;
        r = '0;
        case (w.command)
            CMD_PUSH: begin
                if (pixels_loaded < total) begin
                    inten = w.intensity[15] ? 64'd0 : {48'd0, w.intensity};
                    wt = (w.row_weight > 17'd65536) ? ONE_Q16 : {47'd0, w.row_weight};
                    row_sum += inten * wt;
                    pixel_prefix[pixels_loaded] = row_sum;
                    if (pixels_loaded % img_w == img_w - 1) begin
                        row = pixels_loaded / img_w;
                        row_total[row] = row_sum;
                        grand_sum += row_sum;
                        row_prefix[row] = grand_sum;
                        row_sum = '0;
                    end
                    pixels_loaded++;
                end
            end
            CMD_CLEAR: clear_load();
            CMD_ROW_CDF, CMD_MARG_CDF, CMD_INTEGRAL: begin
                if (pixels_loaded < total) begin
                    r.status = ST_NOT_READY;
                end else if (w.command == CMD_ROW_CDF) begin
                    row = w.row_index;
                    col = w.entry_index;
                    if (row >= img_h || col > img_w) r.status = ST_RANGE;
                    else if (col != 0) begin
                        if (row_total[row] == 0) r.value = 32'((64'(col) * ONE_Q16) / img_w);
                        else r.value = q16_ratio(pixel_prefix[row*img_w + col - 1],
                                                 row_total[row]);
                    end
                end else if (w.command == CMD_MARG_CDF) begin
                    col = w.entry_index;
                    if (col > img_h) r.status = ST_RANGE;
                    else if (col != 0) begin
                        if (grand_sum == 0) r.value = 32'((64'(col) * ONE_Q16) / img_h);
                        else r.value = q16_ratio(row_prefix[col - 1], grand_sum);
                    end
                end else begin
                    mean = grand_sum / total;
                    scaled = (mean * 64'(TWO_PI_SQ_Q16)) >> 24;
                    r.value = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
                end
                cdf_results_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        predict_word(w);
        words_sent++;
        @(negedge aclk);
    endtask

    // wait until every read has answered, then let queued pushes settle
    task automatic drain();
        s_valid <= 1'b0;
        while (cdf_results_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [8:0] val);
        int unsigned v;
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_WIDTH) begin
            v = val;
            img_w = (v < 1) ? 1 : (v > MAX_W) ? MAX_W : v;
        end else begin
            v = val[7:0];
            img_h = (v < 1) ? 1 : (v > MAX_H) ? MAX_H : v;
        end
        clear_load();
    endtask

    task automatic push_pixel(input logic [15:0] inten, input logic [16:0] wt);
        in_word_t w;
        w = '0;
        w.command = CMD_PUSH;
        w.intensity = inten;
        w.row_weight = wt;
        send_word(w);
    endtask

    task automatic read_word(input logic [2:0] cmd, input logic [6:0] row, input logic [8:0] idx);
        in_word_t w;
        w = in_word_t'($bits(in_word_t)'({$urandom, $urandom}));
        w.command = cmd;
        w.row_index = row;
        w.entry_index = idx;
        send_word(w);
    endtask

    function automatic logic [15:0] rand_intensity();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h0000;
            2: return 16'h8000 | 16'($urandom);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(7))
            0: return 17'd65536;
            1: return 17'h1FFFF;
            2: return 17'd0;
            default: return 17'($urandom);
        endcase
    endfunction

    // mostly in-range reads, a few with raw random indexes
    task automatic random_read();
        logic [2:0] cmd;
        logic [6:0] row;
        logic [8:0] idx;
        case ($urandom_range(2))
            0: cmd = CMD_ROW_CDF;
            1: cmd = CMD_MARG_CDF;
            default: cmd = CMD_INTEGRAL;
        endcase
        row = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(img_h - 1));
        if ($urandom_range(9) == 0) idx = 9'($urandom);
        else if (cmd == CMD_MARG_CDF) idx = 9'($urandom_range(img_h));
        else idx = 9'($urandom_range(img_w));
        read_word(cmd, row, idx);
    endtask

    // zero_kind: 0 random pixels, 1 some zero rows, 2 all zero
    task automatic load_image(input int zero_kind);
        int unsigned n;
        bit zero_row;
        zero_row = 0;
        for (n = 0; n < img_w * img_h; n++) begin
            if (n % img_w == 0) zero_row = (zero_kind == 2) || (zero_kind == 1 && $urandom_range(1));
            if ($urandom_range(29) == 0) random_read();
            if (zero_row) push_pixel($urandom_range(1) ? 16'h0 : (16'h8000 | 16'($urandom)),
                                     rand_weight());
            else push_pixel(rand_intensity(), rand_weight());
        end
        loads_done++;
    endtask

    task automatic test_directed();
        write_reg(CFG_WIDTH, 9'd2);
        write_reg(CFG_HEIGHT, 9'd2);
        read_word(CMD_ROW_CDF, 7'd0, 9'd1);
        read_word(CMD_MARG_CDF, 7'd0, 9'd1);
        read_word(CMD_INTEGRAL, 7'd0, 9'd0);
        push_pixel(16'h7FFF, 17'd65536);
        push_pixel(16'h8000, 17'h1FFFF);
        push_pixel(16'h7FFF, 17'h1FFFF);
        push_pixel(16'h0100, 17'd0);
        push_pixel(16'h7FFF, 17'd65536);
        read_word(CMD_ROW_CDF, 7'd0, 9'd0);
        read_word(CMD_ROW_CDF, 7'd0, 9'd1);
        read_word(CMD_ROW_CDF, 7'd0, 9'd2);
        read_word(CMD_ROW_CDF, 7'd1, 9'd3);
        read_word(CMD_ROW_CDF, 7'd2, 9'd1);
        read_word(CMD_ROW_CDF, 7'h7F, 9'h1FF);
        read_word(CMD_MARG_CDF, 7'd0, 9'd0);
        read_word(CMD_MARG_CDF, 7'd0, 9'd1);
        read_word(CMD_MARG_CDF, 7'd0, 9'd2);
        read_word(CMD_MARG_CDF, 7'd0, 9'd3);
        read_word(CMD_INTEGRAL, 7'd0, 9'd0);
        read_word(3'd5, 7'd0, 9'd0);
        read_word(3'd7, 7'd0, 9'd0);
        read_word(CMD_CLEAR, 7'd0, 9'd0);
        read_word(CMD_INTEGRAL, 7'd0, 9'd0);
    endtask

    // register extremes, including saturation of out-of-range writes
    task automatic test_register_extremes();
        write_reg(CFG_WIDTH, 9'h1FF);
        write_reg(CFG_HEIGHT, 9'd1);
        load_image(0);
        repeat (12) random_read();
        write_reg(CFG_HEIGHT, 9'h1FF);
        write_reg(CFG_WIDTH, 9'd0);
        load_image(1);
        repeat (12) random_read();
        write_reg(CFG_HEIGHT, 9'd0);
        load_image(2);
        repeat (4) random_read();
        write_reg(CFG_WIDTH, 9'd256);
        write_reg(CFG_HEIGHT, 9'd128);
        repeat (4) random_read();
        write_reg(CFG_WIDTH, 9'd300);
        write_reg(CFG_HEIGHT, 9'd200);
        write_reg(CFG_WIDTH, 9'd3);
        write_reg(CFG_HEIGHT, 9'd3);
        load_image(2);
        repeat (8) random_read();
    endtask

    task automatic test_random(input int unsigned target);
        int unsigned n;
        while (words_sent < target) begin
            if ($urandom_range(6) == 0) begin
                write_reg(CFG_HEIGHT, 9'($urandom_range(1, 12)));
                write_reg(CFG_WIDTH, 9'($urandom_range(1, 40)));
            end else begin
                write_reg(CFG_WIDTH, 9'($urandom_range(1, 8)));
                write_reg(CFG_HEIGHT, 9'($urandom_range(1, 6)));
            end
            if ($urandom_range(9) == 0) begin
                // broken load: up to a full image of pixels, one read, then clear
                repeat ($urandom_range(1, img_w * img_h)) push_pixel(rand_intensity(), rand_weight());
                random_read();
                read_word(CMD_CLEAR, 7'($urandom), 9'($urandom));
            end
            load_image($urandom_range(9) < 7 ? 0 : $urandom_range(1, 2));
            for (n = $urandom_range(6, 14); n > 0; n--) begin
                case ($urandom_range(19))
                    0: push_pixel(rand_intensity(), rand_weight());
                    1: read_word(3'($urandom_range(5, 7)), 7'($urandom), 9'($urandom));
                    default: random_read();
                endcase
            end
        end
    endtask

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (cdf_results_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word value=%0d status=%0d", $time,
                         m_data.value, m_data.status);
            end else begin
                want = cdf_results_q.pop_front();
                if (m_data.value !== want.value) begin
                    errors++;
                    $display("%0t: value mismatch expected %0d actual %0d", $time,
                             want.value, m_data.value);
                end
                if (m_data.status !== want.status) begin
                    errors++;
                    $display("%0t: status mismatch expected %0d actual %0d", $time,
                             want.status, m_data.status);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("importance_sampling_cdf_builder_top_tb failed");
            $finish;
        end
    end

    initial begin
        img_w = MAX_W;
        img_h = MAX_H;
        clear_load();
        words_sent = 0;
        results_seen = 0;
        loads_done = 0;
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 32;
        recv_idle_pct = 69;
        test_directed();
        test_register_extremes();
        test_random(words_sent + 250);
        send_idle_pct = 69;
        recv_idle_pct = 32;
        test_random(words_sent + 250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(words_sent + 180);

        s_valid <= 1'b0;
        while (cdf_results_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (cdf_results_q.size() != 0) errors++;

        $display("sent %0d words over %0d image loads, checked %0d results",
                 words_sent, loads_done, results_seen);
        $display("loads ran from 1x1 up to 256x1 and 1x128 under three idle patterns");
        if (errors == 0) begin
            $display("importance_sampling_cdf_builder_top_tb passed");
        end else begin
            $display("importance_sampling_cdf_builder_top_tb failed");
        end
        $finish;
    end

endmodule

### importance_sampling_cdf_builder_top.f
rtl/iscdf_pkg.sv
rtl/iscdf_ram.sv
rtl/iscdf_front.sv
rtl/iscdf_back.sv
rtl/importance_sampling_cdf_builder_top.sv
rtl/iscdf_checker.sv
bench/importance_sampling_cdf_builder_top_tb.sv
